@@ hdl/bbc_pkg.sv @@
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants for the bracket balance checker
// Character codes, bracket kinds and the command word passed from the
// classifier to the stack engine.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int STACK_DEPTH_DEFAULT = 64;
  localparam int QUEUE_DEPTH         = 2;
  localparam int COUNT_W             = 7;

  localparam logic [7:0] CHAR_OPEN_PAREN    = 8'h28;  // (
  localparam logic [7:0] CHAR_CLOSE_PAREN   = 8'h29;  // )
  localparam logic [7:0] CHAR_OPEN_SQUARE   = 8'h5B;  // [
  localparam logic [7:0] CHAR_CLOSE_SQUARE  = 8'h5D;  // ]
  localparam logic [7:0] CHAR_OPEN_CURLY    = 8'h7B;  // {
  localparam logic [7:0] CHAR_CLOSE_CURLY   = 8'h7D;  // }

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_PAREN  = 2'd0;
  localparam kind_t KIND_SQUARE = 2'd1;
  localparam kind_t KIND_CURLY  = 2'd2;

  // One command for the stack engine
  typedef struct packed {
    logic  push;
    logic  pop;
    kind_t kind;
    logic  last;
  } cmd_t;

endpackage

@@ hdl/bbc_ram.sv @@
// ----------------------------------------------------------------------------
// bbc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/bbc_front.sv @@
// ----------------------------------------------------------------------------
// bbc_front: character classifier
// Turns each input word into a stack command; drops words that are neither
// a bracket nor the end of the expression.
// ----------------------------------------------------------------------------
module bbc_front (
  input  logic          valid,
  output logic          ready,
  input  logic [7:0]    character,
  input  logic          last,
  output logic          q_valid,
  input  logic          q_ready,
  output bbc_pkg::cmd_t q_word
);

  logic          is_open;
  logic          is_close;
  bbc_pkg::kind_t kind;

  always_comb begin
    is_open  = 1'b0;
    is_close = 1'b0;
    kind     = bbc_pkg::KIND_PAREN;
    case (character)
      bbc_pkg::CHAR_OPEN_PAREN: begin
        is_open = 1'b1;
        kind    = bbc_pkg::KIND_PAREN;
      end
      bbc_pkg::CHAR_OPEN_SQUARE: begin
        is_open = 1'b1;
        kind    = bbc_pkg::KIND_SQUARE;
      end
      bbc_pkg::CHAR_OPEN_CURLY: begin
        is_open = 1'b1;
        kind    = bbc_pkg::KIND_CURLY;
      end
      bbc_pkg::CHAR_CLOSE_PAREN: begin
        is_close = 1'b1;
        kind     = bbc_pkg::KIND_PAREN;
      end
      bbc_pkg::CHAR_CLOSE_SQUARE: begin
        is_close = 1'b1;
        kind     = bbc_pkg::KIND_SQUARE;
      end
      bbc_pkg::CHAR_CLOSE_CURLY: begin
        is_close = 1'b1;
        kind     = bbc_pkg::KIND_CURLY;
      end
      default: begin
        is_open  = 1'b0;
        is_close = 1'b0;
      end
    endcase
  end

  assign q_word.push = is_open;
  assign q_word.pop  = is_close;
  assign q_word.kind = kind;
  assign q_word.last = last;

  // Plain characters never reach the queue unless they end the expression
  assign q_valid = valid & (is_open | is_close | last);
  assign ready   = q_ready;

endmodule

@@ hdl/bbc_queue.sv @@
// ----------------------------------------------------------------------------
// bbc_queue: short command queue
// Register-based FIFO between classifier and stack engine.
// ----------------------------------------------------------------------------
module bbc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  bbc_pkg::cmd_t push_word,
  output logic          pop_valid,
  input  logic          pop_ready,
  output bbc_pkg::cmd_t pop_word
);

  localparam int PW = $clog2(bbc_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(bbc_pkg::QUEUE_DEPTH + 1);

  bbc_pkg::cmd_t  entry [bbc_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = count != CW'(bbc_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_word   = entry[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(bbc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(bbc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_word;
    end
  end

endmodule

@@ hdl/bbc_back.sv @@
// ----------------------------------------------------------------------------
// bbc_back: bracket stack engine
// Top of stack and the entry below it live in registers; deeper entries in
// RAM, prefetched one pop ahead. Holds the result register.
// ----------------------------------------------------------------------------
module bbc_back #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  bbc_pkg::cmd_t               q_word,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic                        balanced,
  output logic                        mismatch_seen,
  output logic [bbc_pkg::COUNT_W-1:0] unclosed_count,
  output logic                        overflow
);

  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [LW-1:0]  level;
  logic [LW-1:0]  level_next;
  bbc_pkg::kind_t tos;
  bbc_pkg::kind_t sec_reg;
  bbc_pkg::kind_t sec_cur;
  bbc_pkg::kind_t ram_rdata;
  logic           use_ram;
  logic           mismatch;
  logic           mismatch_next;
  logic           ovf;
  logic           ovf_next;
  logic           take;
  logic           is_full;
  logic           is_empty;
  logic           do_push;
  logic           do_pop;
  logic           do_mis;
  logic           do_ovf;
  logic [LW-1:0]  waddr_full;
  logic [LW-1:0]  raddr_full;

  // Stall only a word marked last while an undelivered result is held
  assign q_ready = ~q_word.last | ~result_valid | result_ready;
  assign take    = q_valid & q_ready;

  assign is_full  = level == LW'(STACK_DEPTH);
  assign is_empty = level == '0;
  // Entry below the top: fresh RAM data right after a pop, else the register
  assign sec_cur  = use_ram ? ram_rdata : sec_reg;

  assign do_push = take & q_word.push & ~is_full;
  assign do_ovf  = take & q_word.push & is_full;
  assign do_pop  = take & q_word.pop & ~is_empty & (tos == q_word.kind);
  assign do_mis  = take & q_word.pop & ~do_pop;

  always_comb begin
    level_next = level;
    if (do_push) begin
      level_next = level + 1'b1;
    end else if (do_pop) begin
      level_next = level - 1'b1;
    end
  end

  assign mismatch_next = mismatch | do_mis;
  assign ovf_next      = ovf | do_ovf;

  // On push the old top goes to entry level-1; on pop entry level-3 is fetched
  assign waddr_full = level - 1'b1;
  assign raddr_full = level - LW'(3);

  bbc_ram #(
    .WIDTH ($bits(bbc_pkg::kind_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (do_push & ~is_empty),
    .waddr (waddr_full[AW-1:0]),
    .wdata (tos),
    .raddr (raddr_full[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      level        <= '0;
      mismatch     <= 1'b0;
      ovf          <= 1'b0;
      use_ram      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      use_ram <= do_pop;
      if (take && q_word.last) begin
        level        <= '0;
        mismatch     <= 1'b0;
        ovf          <= 1'b0;
        result_valid <= 1'b1;
      end else begin
        level    <= level_next;
        mismatch <= mismatch_next;
        ovf      <= ovf_next;
        if (result_ready) begin
          result_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      tos <= q_word.kind;
    end else if (do_pop) begin
      tos <= sec_cur;
    end
    sec_reg <= do_push ? tos : sec_cur;
    if (take && q_word.last) begin
      balanced       <= ~mismatch_next & ~ovf_next & (level_next == '0);
      mismatch_seen  <= mismatch_next;
      unclosed_count <= bbc_pkg::COUNT_W'(level_next);
      overflow       <= ovf_next;
    end
  end

endmodule

@@ hdl/bracket_balance_checker.sv @@
// ----------------------------------------------------------------------------
// bracket_balance_checker: streaming bracket nesting checker
// Checks ( [ { nesting of an ASCII expression, one character word per cycle when not stalled.
// ----------------------------------------------------------------------------
// Feed the expression one character per word on the input channel and mark
// its final character with last. Openers are pushed onto a stack of
// STACK_DEPTH bracket kinds, matching closers pop it, a wrong or unexpected
// closer sets a sticky mismatch flag, and an opener on a full stack sets a
// sticky overflow flag and is dropped. The word marked last produces exactly
// one result word: balanced, mismatch_seen, unclosed_count (stack level,
// low 7 bits) and overflow; then all state clears for the next expression.
// Throughput is one character per cycle sustained, except while a last word
// waits for an earlier result; it rests on the top-of-stack compare and
// level update in the stack engine. result_valid is registered by the stack
// engine at the edge where it takes the last word out of the command queue.
// A new expression may start while a result still waits; only a further last
// word stalls until that result is taken.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module bracket_balance_checker #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  // character stream
  input  logic                        valid,
  output logic                        ready,
  input  logic [7:0]                  character,
  input  logic                        last,
  // result stream
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic                        balanced,
  output logic                        mismatch_seen,
  output logic [bbc_pkg::COUNT_W-1:0] unclosed_count,
  output logic                        overflow
);

  // classifier -> queue
  logic          fq_valid;
  logic          fq_ready;
  bbc_pkg::cmd_t fq_word;
  // queue -> stack engine
  logic          qb_valid;
  logic          qb_ready;
  bbc_pkg::cmd_t qb_word;

  // Front: decode character into push / pop / end-only command
  bbc_front u_front (
    .valid     (valid),
    .ready     (ready),
    .character (character),
    .last      (last),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_word    (fq_word)
  );

  // Decoupling queue so the front keeps accepting while the back stalls, until the queue fills
  bbc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_word  (fq_word),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_word   (qb_word)
  );

  // Back: stack, sticky flags and result register
  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (qb_valid),
    .q_ready        (qb_ready),
    .q_word         (qb_word),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .balanced       (balanced),
    .mismatch_seen  (mismatch_seen),
    .unclosed_count (unclosed_count),
    .overflow       (overflow)
  );

endmodule

@@ tb/nesting_monitor.sv @@
// ----------------------------------------------------------------------------
// nesting_monitor: predictor and result checker for the bracket balance checker
// Watches the character and result channels and tracks bracket nesting on
// its own. It builds one expected verdict for each word marked last and
// compares every result word, field by field, with the oldest one waiting.
// ----------------------------------------------------------------------------
module nesting_monitor #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        valid,
  input  logic                        ready,
  input  logic [7:0]                  character,
  input  logic                        last,
  input  logic                        result_valid,
  input  logic                        result_ready,
  input  logic                        balanced,
  input  logic                        mismatch_seen,
  input  logic [bbc_pkg::COUNT_W-1:0] unclosed_count,
  input  logic                        overflow,
  output int                          fails,
  output int                          pending
);

  typedef struct {
    bit                        balanced;
    bit                        mismatch;
    bit [bbc_pkg::COUNT_W-1:0] open_count;
    bit                        overflow;
  } verdict_t;

  verdict_t       verdicts[$];
  bbc_pkg::kind_t nest_kinds[STACK_DEPTH];
  int unsigned    nest_level;
  bit             mismatch_flag;
  bit             overflow_flag;

  task automatic report(string what, int got, int want);
    fails++;
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic clear_nesting();
    nest_level    = 0;
    mismatch_flag = 0;
    overflow_flag = 0;
  endtask

  // opener on a full stack is dropped and flags overflow
  task automatic take_opener(bbc_pkg::kind_t k);
    if (nest_level >= STACK_DEPTH) begin
      overflow_flag = 1;
    end else begin
      nest_kinds[nest_level] = k;
      nest_level++;
    end
  endtask

  // closer on empty stack or wrong kind: sticky mismatch, stack untouched
  task automatic take_closer(bbc_pkg::kind_t k);
    if (nest_level == 0 || nest_kinds[nest_level-1] != k) begin
      mismatch_flag = 1;
    end else begin
      nest_level--;
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      verdicts.delete();
      clear_nesting();
    end else begin
      if (result_valid && result_ready) begin
        if (verdicts.size() == 0) begin
          report("result with none expected", 1, 0);
        end else begin
          want = verdicts.pop_front();
          if (balanced !== want.balanced)
            report("balanced", int'(balanced), int'(want.balanced));
          if (mismatch_seen !== want.mismatch)
            report("mismatch_seen", int'(mismatch_seen), int'(want.mismatch));
          if (unclosed_count !== want.open_count)
            report("unclosed_count", int'(unclosed_count), int'(want.open_count));
          if (overflow !== want.overflow)
            report("overflow", int'(overflow), int'(want.overflow));
        end
      end
      if (valid && ready) begin
        case (character)
          bbc_pkg::CHAR_OPEN_PAREN:   take_opener(bbc_pkg::KIND_PAREN);
          bbc_pkg::CHAR_OPEN_SQUARE:  take_opener(bbc_pkg::KIND_SQUARE);
          bbc_pkg::CHAR_OPEN_CURLY:   take_opener(bbc_pkg::KIND_CURLY);
          bbc_pkg::CHAR_CLOSE_PAREN:  take_closer(bbc_pkg::KIND_PAREN);
          bbc_pkg::CHAR_CLOSE_SQUARE: take_closer(bbc_pkg::KIND_SQUARE);
          bbc_pkg::CHAR_CLOSE_CURLY:  take_closer(bbc_pkg::KIND_CURLY);
          default: ;
        endcase
        if (last) begin
          want.balanced   = !mismatch_flag && !overflow_flag && nest_level == 0;
          want.mismatch   = mismatch_flag;
          want.open_count = nest_level[bbc_pkg::COUNT_W-1:0];
          want.overflow   = overflow_flag;
          verdicts.push_back(want);
          clear_nesting();
        end
      end
    end
    pending = verdicts.size();
  end

endmodule

@@ tb/bracket_balance_checker_test.sv @@
// ----------------------------------------------------------------------------
// bracket_balance_checker_test: top level testbench for the bracket checker
// Drives expressions one character word at a time, directed cases first and
// then random nestings, deep stacks and noise, with random gaps on both
// channels. A nesting_monitor beside the block predicts and checks results.
// ----------------------------------------------------------------------------
module bracket_balance_checker_test;

  localparam int DEPTH       = bbc_pkg::STACK_DEPTH_DEFAULT;
  localparam int WORD_TARGET = 1800;   // input words to send

  // six bracket characters: openers at 0..2, matching closers at 3..5
  localparam logic [47:0] BRACKET_CHARS = {bbc_pkg::CHAR_CLOSE_CURLY,
                                           bbc_pkg::CHAR_CLOSE_SQUARE,
                                           bbc_pkg::CHAR_CLOSE_PAREN,
                                           bbc_pkg::CHAR_OPEN_CURLY,
                                           bbc_pkg::CHAR_OPEN_SQUARE,
                                           bbc_pkg::CHAR_OPEN_PAREN};

  logic                        clk          = 0;
  logic                        rst          = 1;
  logic                        valid        = 0;
  logic                        ready;
  logic [7:0]                  character    = 0;
  logic                        last         = 0;
  logic                        result_valid;
  logic                        result_ready = 0;
  logic                        balanced;
  logic                        mismatch_seen;
  logic [bbc_pkg::COUNT_W-1:0] unclosed_count;
  logic                        overflow;

  int         fails;
  int         pending;
  int         sent_words = 0;
  bit         calm       = 0;  // no idling on either side while set
  logic [7:0] expr[$];         // expression being built
  int         open_kinds[$];   // generator's own view of open brackets

  bracket_balance_checker #(.STACK_DEPTH(DEPTH)) uut (
    .clk           (clk),
    .rst           (rst),
    .valid         (valid),
    .ready         (ready),
    .character     (character),
    .last          (last),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .balanced      (balanced),
    .mismatch_seen (mismatch_seen),
    .unclosed_count(unclosed_count),
    .overflow      (overflow)
  );

  nesting_monitor #(.STACK_DEPTH(DEPTH)) monitor (
    .clk           (clk),
    .rst           (rst),
    .valid         (valid),
    .ready         (ready),
    .character     (character),
    .last          (last),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .balanced      (balanced),
    .mismatch_seen (mismatch_seen),
    .unclosed_count(unclosed_count),
    .overflow      (overflow),
    .fails         (fails),
    .pending       (pending)
  );

  always #2 clk = ~clk;

  // hard stop well past the slowest legal run
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // Present one word and hold it until taken. Called at a rising edge, so
  // valid either stays high into the next word or drops for the gap.
  task automatic send_word(logic [7:0] ch, logic lst);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      valid <= 0;
      repeat (gap) @(posedge clk);
    end
    valid     <= 1;
    character <= ch;
    last      <= lst;
    @(posedge clk);
    while (!ready) @(posedge clk);
    sent_words++;
  endtask

  // send the built expression, last on its final character
  task automatic send_expr();
    for (int i = 0; i < expr.size(); i++)
      send_word(expr[i], i == expr.size() - 1);
    expr.delete();
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++)
      expr.push_back(s[i]);
  endtask

  // run of depth openers with occasional random bytes, then up to closes matching closers
  task automatic build_deep(int depth, int closes);
    int k;
    for (int i = 0; i < depth; i++) begin
      k = $urandom_range(0, 2);
      expr.push_back(BRACKET_CHARS[8*k +: 8]);
      open_kinds.push_back(k);
      if ($urandom_range(0, 15) == 0)
        expr.push_back(8'($urandom_range(0, 255)));
    end
    for (int i = 0; i < closes && open_kinds.size() > 0; i++) begin
      k = open_kinds.pop_back();
      expr.push_back(BRACKET_CHARS[8*(k+3) +: 8]);
    end
    open_kinds.delete();
  endtask

  // Result side: per result word, hold ready low for a random stall (none while
  // calm is set), then wait for the word. Ready may sit high before valid comes up.
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        result_ready <= 0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  initial begin
    int mode;
    int len;
    int limit;
    int k;
    int r;
    int pos;
    repeat (10) @(posedge clk);
    rst <= 0;

    // --- directed ---
    queue_text("()");      send_expr();  // simplest balanced pair
    queue_text("([{}])");  send_expr();  // all three kinds nested
    queue_text(")");       send_expr();  // closer with nothing open
    queue_text("(]");      send_expr();  // wrong kind, opener stays
    queue_text("())");     send_expr();  // extra closer after emptying
    queue_text("[(})]");   send_expr();  // mismatch, then stack closes cleanly
    queue_text("[[");      send_expr();  // ends on an opener, two left open
    // extreme ignored bytes inside a pair
    queue_text("{");
    expr.push_back(8'h00);
    expr.push_back(8'hFF);
    queue_text("}");
    send_expr();
    // lone ignored byte marked last: empty and balanced
    expr.push_back(8'h00);
    send_expr();

    // stack exactly full then fully closed, and overflow left at full depth
    build_deep(DEPTH, DEPTH);
    send_expr();
    build_deep(DEPTH + 2, 0);
    send_expr();

    // --- random ---
    while (sent_words < WORD_TARGET) begin
      calm = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 19);
      if (mode < 14) begin
        // well-formed nesting with noise, occasionally broken at the end or at a random byte
        len   = $urandom_range(2, 40);
        limit = ($urandom_range(0, 7) == 0) ? DEPTH + 1 : $urandom_range(1, 8);
        while (expr.size() < len) begin
          r = $urandom_range(0, 9);
          if (r < 2) begin
            expr.push_back(8'($urandom_range(0, 255)));
          end else if (open_kinds.size() == 0 ||
                       (r < 6 && open_kinds.size() < limit)) begin
            k = $urandom_range(0, 2);
            expr.push_back(BRACKET_CHARS[8*k +: 8]);
            open_kinds.push_back(k);
          end else begin
            k = open_kinds.pop_back();
            expr.push_back(BRACKET_CHARS[8*(k+3) +: 8]);
          end
        end
        while (open_kinds.size() > 0) begin
          k = open_kinds.pop_back();
          expr.push_back(BRACKET_CHARS[8*(k+3) +: 8]);
        end
        r = $urandom_range(0, 9);
        if (r == 0) begin
          void'(expr.pop_back());   // drops the final byte; if it was a closer, one bracket stays open
        end else if (r == 1) begin
          pos       = $urandom_range(0, expr.size() - 1);
          k         = $urandom_range(0, 5);
          expr[pos] = BRACKET_CHARS[8*k +: 8];
        end
      end else if (mode < 15) begin
        build_deep($urandom_range(DEPTH - 4, DEPTH + 4), $urandom_range(0, DEPTH + 4));
      end else begin
        // noise: random bytes, each one a bracket or any byte with even odds
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 1)) begin
            k = $urandom_range(0, 5);
            expr.push_back(BRACKET_CHARS[8*k +: 8]);
          end else begin
            expr.push_back(8'($urandom_range(0, 255)));
          end
        end
      end
      send_expr();
    end

    // drain: last word was just taken at this edge
    valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
